[sv/sda_pkg.sv]
`timescale 1ns / 1ps
// sda_pkg: field widths, operation and direction codes and register indexes
// for the scroll delta accumulator. No dependencies.

package sda_pkg;

   localparam int OP_WIDTH        = 2;
   localparam int POINTER_WIDTH   = 8;
   localparam int SOURCE_WIDTH    = 3;
   localparam int DIR_WIDTH       = 3;
   localparam int DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 1;

   localparam int DEFAULT_FRAC_BITS = 16;

   // operation codes
   localparam logic [OP_WIDTH-1:0] OP_SCROLL = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_LEAVE  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CANCEL = 2'd2;

   // direction codes
   localparam logic [DIR_WIDTH-1:0] DIR_UP     = 3'd0;
   localparam logic [DIR_WIDTH-1:0] DIR_DOWN   = 3'd1;
   localparam logic [DIR_WIDTH-1:0] DIR_LEFT   = 3'd2;
   localparam logic [DIR_WIDTH-1:0] DIR_RIGHT  = 3'd3;
   localparam logic [DIR_WIDTH-1:0] DIR_SMOOTH = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HORIZONTAL_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTICAL_ENABLE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHYSICAL_DIRECTION = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISCRETE_MODE      = 2'd3;

endpackage

[sv/sda_if.sv]
`timescale 1ns / 1ps
// sda_req_if and sda_rsp_if: valid/ready channels for scroll events and
// scroll reports. Depends on sda_pkg for field widths.

interface sda_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [sda_pkg::OP_WIDTH-1:0]      op;
   logic        [sda_pkg::POINTER_WIDTH-1:0] pointer_id;
   logic        [sda_pkg::SOURCE_WIDTH-1:0]  scroll_source;
   logic        [sda_pkg::DIR_WIDTH-1:0]     direction;
   logic signed [sda_pkg::DATA_WIDTH-1:0]    delta_x;
   logic signed [sda_pkg::DATA_WIDTH-1:0]    delta_y;
   logic                                    inverted;
   logic                                    emulated;

   modport source (output valid, op, pointer_id, scroll_source, direction, delta_x, delta_y,
                   inverted, emulated, input ready);
   modport sink   (input valid, op, pointer_id, scroll_source, direction, delta_x, delta_y,
                   inverted, emulated, output ready);
endinterface

interface sda_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    emit;
   logic        [sda_pkg::POINTER_WIDTH-1:0] out_pointer;
   logic        [sda_pkg::SOURCE_WIDTH-1:0]  out_source;
   logic signed [sda_pkg::DATA_WIDTH-1:0]    step_x;
   logic signed [sda_pkg::DATA_WIDTH-1:0]    step_y;

   modport source (output valid, emit, out_pointer, out_source, step_x, step_y,
                   input ready);
   modport sink   (input valid, emit, out_pointer, out_source, step_x, step_y,
                   output ready);
endinterface

[sv/scroll_delta_accumulator.sv]
`timescale 1ns / 1ps
// scroll_delta_accumulator: saturating X/Y scroll accumulation per pointer and
// source, with whole-step or full-sum reporting. Depends on sda_pkg, sda_if.
//
//   channel  dir  handshake         carries
//   req      in   valid/ready       op, pointer, source, direction, deltas, flags
//   rsp      out  valid/ready       emit, pointer, source, step_x, step_y
//   csr      in   write enable      index, one data bit
//
// Every event yields one report beat via the input and result registers;
// one event is taken per cycle unless rsp stalls, set by the single update
// pass from the input register into the accumulators and the result register.
// Reset (synchronous) clears configuration, valid flags, accumulators, tracking.
// A stall on rsp holds the result register and blocks the input register.

module scroll_delta_accumulator #(
   parameter int FRAC_BITS = sda_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sda_req_if.sink                              req,
   sda_rsp_if.source                            rsp,
   input  logic                                 csr_write_enable,
   input  logic [sda_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sda_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import sda_pkg::*;

   localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] FRAC_MASK = DATA_WIDTH'(ONE) - DATA_WIDTH'(1);
   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_neg(
      input logic signed [DATA_WIDTH-1:0] a);
      if (a == SAT_MIN) begin
         return SAT_MAX;
      end
      return -a;
   endfunction

   // whole units, truncated toward zero
   function automatic logic signed [DATA_WIDTH-1:0] whole_part(
      input logic signed [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] floor_v;
      floor_v = v & ~FRAC_MASK;
      if (v[DATA_WIDTH-1] && ((v & FRAC_MASK) != '0)) begin
         return floor_v + ONE;
      end
      return floor_v;
   endfunction

   // configuration registers
   logic horizontal_enable_ff, vertical_enable_ff, physical_direction_ff, discrete_mode_ff;

   // accumulator and tracking state
   logic signed [DATA_WIDTH-1:0]    sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic        [POINTER_WIDTH-1:0] tracked_pointer_ff, tracked_pointer_in;
   logic        [SOURCE_WIDTH-1:0]  tracked_source_ff, tracked_source_in;
   logic                            tracked_valid_ff, tracked_valid_in;

   // input register
   logic                            in_valid_ff;
   logic        [OP_WIDTH-1:0]      in_op_ff;
   logic        [POINTER_WIDTH-1:0] in_pointer_ff;
   logic        [SOURCE_WIDTH-1:0]  in_source_ff;
   logic        [DIR_WIDTH-1:0]     in_direction_ff;
   logic signed [DATA_WIDTH-1:0]    in_delta_x_ff, in_delta_y_ff;
   logic                            in_inverted_ff, in_emulated_ff;

   // result register
   logic                            out_valid_ff;
   logic                            out_emit_ff, out_emit_in;
   logic        [POINTER_WIDTH-1:0] out_pointer_ff, out_pointer_in;
   logic        [SOURCE_WIDTH-1:0]  out_source_ff, out_source_in;
   logic signed [DATA_WIDTH-1:0]    out_step_x_ff, out_step_x_in;
   logic signed [DATA_WIDTH-1:0]    out_step_y_ff, out_step_y_in;

   logic advance;

   // the input register moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // event update
   always_comb begin
      logic                         scroll, ends_sequence, restart;
      logic signed [DATA_WIDTH-1:0] base_x, base_y, add_x, add_y, acc_x, acc_y;
      logic signed [DATA_WIDTH-1:0] rep_x, rep_y;

      scroll        = (in_op_ff == OP_SCROLL) && !in_emulated_ff;
      ends_sequence = (in_op_ff == OP_LEAVE) || (in_op_ff == OP_CANCEL);
      restart       = !tracked_valid_ff || (tracked_pointer_ff != in_pointer_ff)
                      || (tracked_source_ff != in_source_ff);

      base_x = restart ? '0 : sum_x_ff;
      base_y = restart ? '0 : sum_y_ff;

      add_x = '0;
      add_y = '0;
      case (in_direction_ff)
         DIR_UP:     add_y = -ONE;
         DIR_DOWN:   add_y = ONE;
         DIR_LEFT:   add_x = -ONE;
         DIR_RIGHT:  add_x = ONE;
         DIR_SMOOTH: begin
            add_x = in_delta_x_ff;
            add_y = in_delta_y_ff;
         end
         default: ;
      endcase

      acc_x = horizontal_enable_ff ? sat_add(base_x, add_x) : '0;
      acc_y = vertical_enable_ff   ? sat_add(base_y, add_y) : '0;

      // inverted scrolling in physical mode flips both axes
      if (physical_direction_ff && in_inverted_ff) begin
         acc_x = sat_neg(acc_x);
         acc_y = sat_neg(acc_y);
      end

      if (discrete_mode_ff) begin
         rep_x = whole_part(acc_x);
         rep_y = whole_part(acc_y);
      end else begin
         rep_x = acc_x;
         rep_y = acc_y;
      end

      // next state
      sum_x_in           = sum_x_ff;
      sum_y_in           = sum_y_ff;
      tracked_pointer_in = tracked_pointer_ff;
      tracked_source_in  = tracked_source_ff;
      tracked_valid_in   = tracked_valid_ff;
      if (scroll) begin
         sum_x_in           = acc_x - rep_x;
         sum_y_in           = acc_y - rep_y;
         tracked_pointer_in = in_pointer_ff;
         tracked_source_in  = in_source_ff;
         tracked_valid_in   = 1'b1;
      end else if (ends_sequence && tracked_valid_ff
                   && (tracked_pointer_ff == in_pointer_ff)) begin
         sum_x_in          = '0;
         sum_y_in          = '0;
         tracked_source_in = '0;
         tracked_valid_in  = 1'b0;
      end

      // report, all zero when nothing moves
      out_emit_in    = scroll && ((rep_x != '0) || (rep_y != '0));
      out_pointer_in = out_emit_in ? in_pointer_ff : '0;
      out_source_in  = out_emit_in ? in_source_ff : '0;
      out_step_x_in  = out_emit_in ? rep_x : '0;
      out_step_y_in  = out_emit_in ? rep_y : '0;
   end

   // control, configuration and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         horizontal_enable_ff  <= 1'b0;
         vertical_enable_ff    <= 1'b0;
         physical_direction_ff <= 1'b0;
         discrete_mode_ff      <= 1'b0;
         sum_x_ff              <= '0;
         sum_y_ff              <= '0;
         tracked_pointer_ff    <= '0;
         tracked_source_ff     <= '0;
         tracked_valid_ff      <= 1'b0;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_HORIZONTAL_ENABLE:  horizontal_enable_ff  <= csr_data[0];
               CSR_VERTICAL_ENABLE:    vertical_enable_ff    <= csr_data[0];
               CSR_PHYSICAL_DIRECTION: physical_direction_ff <= csr_data[0];
               CSR_DISCRETE_MODE:      discrete_mode_ff      <= csr_data[0];
               default: ;
            endcase
         end
         if (advance) begin
            sum_x_ff           <= sum_x_in;
            sum_y_ff           <= sum_y_in;
            tracked_pointer_ff <= tracked_pointer_in;
            tracked_source_ff  <= tracked_source_in;
            tracked_valid_ff   <= tracked_valid_in;
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff        <= req.op;
         in_pointer_ff   <= req.pointer_id;
         in_source_ff    <= req.scroll_source;
         in_direction_ff <= req.direction;
         in_delta_x_ff   <= req.delta_x;
         in_delta_y_ff   <= req.delta_y;
         in_inverted_ff  <= req.inverted;
         in_emulated_ff  <= req.emulated;
      end
      if (advance) begin
         out_emit_ff    <= out_emit_in;
         out_pointer_ff <= out_pointer_in;
         out_source_ff  <= out_source_in;
         out_step_x_ff  <= out_step_x_in;
         out_step_y_ff  <= out_step_y_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.emit        = out_emit_ff;
   assign rsp.out_pointer = out_pointer_ff;
   assign rsp.out_source  = out_source_ff;
   assign rsp.step_x      = out_step_x_ff;
   assign rsp.step_y      = out_step_y_ff;

endmodule

[dv/sda_checker.sv]
`timescale 1ns / 1ps
// sda_checker: watches the scroll event, report and register ports, predicts
// each report beat and compares it field by field. Depends on sda_pkg, sda_if.

module sda_checker (
   input  logic                                clock,
   input  logic                                reset,
   sda_req_if                                  req,
   sda_rsp_if                                  rsp,
   input  logic                                csr_write_enable,
   input  logic [sda_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sda_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  reports_pending
);
   import sda_pkg::*;

   localparam int     FRAC_BITS = DEFAULT_FRAC_BITS;
   localparam longint SAT_MAX   = 64'sd2147483647;
   localparam longint SAT_MIN   = -64'sd2147483648;

   typedef struct packed {
      logic                            emit;
      logic [POINTER_WIDTH-1:0]        pointer;
      logic [SOURCE_WIDTH-1:0]         src;
      logic signed [DATA_WIDTH-1:0]    step_x;
      logic signed [DATA_WIDTH-1:0]    step_y;
   } scroll_report_type;

   // shadow of the control registers
   logic horizontal_on, vertical_on, physical_on, discrete_on;

   // shadow of the accumulators and pointer tracking
   longint                   acc_x, acc_y;
   logic [POINTER_WIDTH-1:0] tracked_pointer;
   logic [SOURCE_WIDTH-1:0]  tracked_src;
   logic                     tracking;

   scroll_report_type expected_reports[$];

   function automatic longint saturate(input longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
   endfunction

   // whole units, truncated toward zero
   function automatic longint whole_units(input longint v);
      longint frac_mask;
      frac_mask = (longint'(1) << FRAC_BITS) - 1;
      if (v >= 0) return v & ~frac_mask;
      return -((-v) & ~frac_mask);
   endfunction

   function automatic void restart_tracking();
      acc_x       = 0;
      acc_y       = 0;
      tracked_src = '0;
      tracking    = 1'b0;
   endfunction

   // one event in, one report out; updates the shadow state
   function automatic scroll_report_type accumulate_event(
      input logic [OP_WIDTH-1:0]      op,
      input logic [POINTER_WIDTH-1:0] pointer_id,
      input logic [SOURCE_WIDTH-1:0]  src,
      input logic [DIR_WIDTH-1:0]     direction,
      input logic signed [DATA_WIDTH-1:0] delta_x,
      input logic signed [DATA_WIDTH-1:0] delta_y,
      input logic                     inverted,
      input logic                     emulated);
      scroll_report_type report;
      longint            unit, out_x, out_y;
      report = '0;
      unit   = longint'(1) << FRAC_BITS;

      // leave and cancel only matter for the tracked pointer
      if (op == OP_LEAVE || op == OP_CANCEL) begin
         if (tracking && tracked_pointer == pointer_id) restart_tracking();
         return report;
      end
      if (op != OP_SCROLL || emulated) return report;

      if (!tracking || tracked_pointer != pointer_id || tracked_src != src)
         restart_tracking();
      tracked_pointer = pointer_id;
      tracked_src     = src;
      tracking        = 1'b1;

      case (direction)
         DIR_UP:     acc_y = saturate(acc_y - unit);
         DIR_DOWN:   acc_y = saturate(acc_y + unit);
         DIR_LEFT:   acc_x = saturate(acc_x - unit);
         DIR_RIGHT:  acc_x = saturate(acc_x + unit);
         DIR_SMOOTH: begin
            acc_x = saturate(acc_x + longint'(delta_x));
            acc_y = saturate(acc_y + longint'(delta_y));
         end
         default: ;
      endcase

      if (!horizontal_on) acc_x = 0;
      if (!vertical_on)   acc_y = 0;

      if (physical_on && inverted) begin
         acc_x = saturate(-acc_x);
         acc_y = saturate(-acc_y);
      end

      // discrete mode keeps the fraction, otherwise everything goes out
      if (discrete_on) begin
         out_x = whole_units(acc_x);
         out_y = whole_units(acc_y);
         acc_x = acc_x - out_x;
         acc_y = acc_y - out_y;
      end else begin
         out_x = acc_x;
         out_y = acc_y;
         acc_x = 0;
         acc_y = 0;
      end

      if (out_x != 0 || out_y != 0) begin
         report.emit    = 1'b1;
         report.pointer = pointer_id;
         report.src     = src;
         report.step_x  = out_x[DATA_WIDTH-1:0];
         report.step_y  = out_y[DATA_WIDTH-1:0];
      end
      return report;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t sda_checker: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      scroll_report_type want;
      if (reset) begin
         horizontal_on   = 1'b0;
         vertical_on     = 1'b0;
         physical_on     = 1'b0;
         discrete_on     = 1'b0;
         tracked_pointer = '0;
         mismatch_count  = 0;
         restart_tracking();
         expected_reports.delete();
      end else begin
         // report beat against the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("report beat with no event waiting");
            end else begin
               want = expected_reports.pop_front();
               if (rsp.emit !== want.emit)
                  report_mismatch($sformatf("emit %b, want %b", rsp.emit, want.emit));
               if (rsp.out_pointer !== want.pointer)
                  report_mismatch($sformatf("out_pointer %0d, want %0d",
                                            rsp.out_pointer, want.pointer));
               if (rsp.out_source !== want.src)
                  report_mismatch($sformatf("out_source %0d, want %0d",
                                            rsp.out_source, want.src));
               if (rsp.step_x !== want.step_x)
                  report_mismatch($sformatf("step_x %h, want %h", rsp.step_x, want.step_x));
               if (rsp.step_y !== want.step_y)
                  report_mismatch($sformatf("step_y %h, want %h", rsp.step_y, want.step_y));
            end
         end

         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HORIZONTAL_ENABLE:  horizontal_on = csr_data[0];
               CSR_VERTICAL_ENABLE:    vertical_on   = csr_data[0];
               CSR_PHYSICAL_DIRECTION: physical_on   = csr_data[0];
               CSR_DISCRETE_MODE:      discrete_on   = csr_data[0];
               default: ;
            endcase
         end

         // event beat
         if (req.valid && req.ready)
            expected_reports.push_back(accumulate_event(req.op, req.pointer_id,
                                                        req.scroll_source,
                                                        req.direction, req.delta_x,
                                                        req.delta_y, req.inverted,
                                                        req.emulated));
      end
      reports_pending <= expected_reports.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives scroll events and register writes into the scroll delta
// accumulator, stalls the report side, and gives the verdict from sda_checker.

module testbench;
   import sda_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TIME  = 4;
   localparam int PHASE_EVENTS = 82;
   localparam int PHASE_COUNT  = 8;
   localparam int IDLE_PERCENT = 24;

   localparam logic [OP_WIDTH-1:0]  OP_UNUSED   = 2'd3;
   localparam logic [DIR_WIDTH-1:0] DIR_UNKNOWN = 3'd7;

   localparam logic signed [DATA_WIDTH-1:0] DELTA_MAX        = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] DELTA_MIN        = 32'sh8000_0000;
   localparam logic signed [DATA_WIDTH-1:0] ONE_AND_HALF     = 32'sh0001_8000;
   localparam logic signed [DATA_WIDTH-1:0] NEG_ONE_AND_HALF = -32'sh0001_8000;
   localparam logic signed [DATA_WIDTH-1:0] QUARTER          = 32'sh0000_4000;

   logic clock;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   int                         mismatch_count;
   int                         reports_pending;
   int                         cycle_count;
   bit                         pacing_on;

   // stream state for well-formed scroll runs
   logic [POINTER_WIDTH-1:0] run_pointer;
   logic [SOURCE_WIDTH-1:0]  run_src;

   sda_req_if req_bus ();
   sda_rsp_if rsp_bus ();

   scroll_delta_accumulator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   sda_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .reports_pending  (reports_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // report side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !(pacing_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // one event beat, with random idle cycles ahead of it
   task automatic send_event(
      input logic [OP_WIDTH-1:0]          op,
      input logic [POINTER_WIDTH-1:0]     pointer_id,
      input logic [SOURCE_WIDTH-1:0]      src,
      input logic [DIR_WIDTH-1:0]         direction,
      input logic signed [DATA_WIDTH-1:0] delta_x,
      input logic signed [DATA_WIDTH-1:0] delta_y,
      input logic                         inverted,
      input logic                         emulated);
      @(negedge clock);
      while (pacing_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.pointer_id    <= pointer_id;
      req_bus.scroll_source <= src;
      req_bus.direction     <= direction;
      req_bus.delta_x       <= delta_x;
      req_bus.delta_y       <= delta_y;
      req_bus.inverted      <= inverted;
      req_bus.emulated      <= emulated;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off events until every report beat has come back
   task automatic wait_for_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (SETTLE_TIME) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [3:0] bits);
      wait_for_idle();
      write_register(CSR_HORIZONTAL_ENABLE,  bits[0]);
      write_register(CSR_VERTICAL_ENABLE,    bits[1]);
      write_register(CSR_PHYSICAL_DIRECTION, bits[2]);
      write_register(CSR_DISCRETE_MODE,      bits[3]);
   endtask

   // mostly small fractional deltas, some extremes and full-range values
   function automatic logic signed [DATA_WIDTH-1:0] random_delta();
      int v;
      case ($urandom_range(9))
         0:       return DELTA_MAX;
         1:       return DELTA_MIN;
         2, 3:    return $urandom();
         default: begin
            v = int'($urandom_range(524288)) - 262144;
            return v;
         end
      endcase
   endfunction

   // random scroll runs on one pointer and source, plus leave, cancel and noise
   task automatic random_phase(input int count);
      logic [OP_WIDTH-1:0]      op;
      logic [POINTER_WIDTH-1:0] pointer_id;
      logic [DIR_WIDTH-1:0]     direction;
      int                       pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 10) begin
            run_pointer = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
            run_src     = 3'($urandom());
         end
         pick = $urandom_range(99);
         if (pick < 86)      op = OP_SCROLL;
         else if (pick < 92) op = OP_LEAVE;
         else if (pick < 98) op = OP_CANCEL;
         else                op = OP_UNUSED;
         pointer_id = ($urandom_range(9) == 0) ? 8'($urandom()) : run_pointer;
         pick = $urandom_range(99);
         if (pick < 40)      direction = DIR_SMOOTH;
         else if (pick < 90) direction = 3'($urandom_range(3));
         else                direction = 3'($urandom_range(7, 5));
         send_event(op, pointer_id, ($urandom_range(19) == 0) ? 3'($urandom()) : run_src,
                    direction, random_delta(), random_delta(), 1'($urandom()),
                    $urandom_range(19) == 0);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      pacing_on             = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_data              = '0;
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_SCROLL;
      req_bus.pointer_id    = '0;
      req_bus.scroll_source = '0;
      req_bus.direction     = DIR_UP;
      req_bus.delta_x       = '0;
      req_bus.delta_y       = '0;
      req_bus.inverted      = 1'b0;
      req_bus.emulated      = 1'b0;
      run_pointer           = '0;
      run_src               = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both axes off after reset: nothing comes out
      send_event(OP_SCROLL, 8'd3, 3'd1, DIR_UP, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd3, 3'd1, DIR_SMOOTH, DELTA_MAX, DELTA_MIN, 1'b1, 1'b0);

      // full-sum reporting: every direction, extremes, ignored events
      apply_settings(4'b0011);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_UP, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_DOWN, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_LEFT, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_RIGHT, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_SMOOTH, DELTA_MAX, DELTA_MIN, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_UNKNOWN, DELTA_MAX, DELTA_MAX, 1'b1, 1'b0);
      send_event(OP_SCROLL, 8'd0, 3'd0, DIR_SMOOTH, DELTA_MAX, DELTA_MAX, 1'b0, 1'b1);
      send_event(OP_UNUSED, 8'd0, 3'd0, DIR_DOWN, 0, 0, 1'b0, 1'b0);
      send_event(OP_LEAVE, 8'd5, 3'd0, DIR_UP, 0, 0, 1'b0, 1'b0);
      send_event(OP_LEAVE, 8'd0, 3'd0, DIR_UP, 0, 0, 1'b0, 1'b0);
      send_event(OP_CANCEL, 8'd0, 3'd0, DIR_UP, 0, 0, 1'b0, 1'b0);

      // whole steps with remainder, inversion, saturation, restarts
      apply_settings(4'b1111);
      send_event(OP_SCROLL, 8'hFF, 3'd7, DIR_SMOOTH, ONE_AND_HALF, NEG_ONE_AND_HALF,
                 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd7, DIR_SMOOTH, ONE_AND_HALF, NEG_ONE_AND_HALF,
                 1'b1, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd7, DIR_SMOOTH, DELTA_MAX, DELTA_MAX, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd7, DIR_SMOOTH, DELTA_MAX, DELTA_MAX, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd7, DIR_SMOOTH, DELTA_MIN, DELTA_MIN, 1'b1, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd6, DIR_SMOOTH, QUARTER, QUARTER, 1'b0, 1'b0);
      send_event(OP_CANCEL, 8'hFF, 3'd6, DIR_UP, 0, 0, 1'b0, 1'b0);
      send_event(OP_SCROLL, 8'hFF, 3'd6, DIR_SMOOTH, DELTA_MIN, DELTA_MIN, 1'b1, 1'b0);
      send_event(OP_SCROLL, 8'h80, 3'd6, DIR_DOWN, 0, 0, 1'b1, 1'b0);

      // random phases, the extremes first, one of them with no idling
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       apply_settings(4'b1111);
            1:       apply_settings(4'b0000);
            2:       apply_settings(4'b1011);
            default: apply_settings(4'($urandom_range(15)));
         endcase
         pacing_on = (phase != 3);
         random_phase(PHASE_EVENTS);
      end
      pacing_on = 1'b1;

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
